>>> rtl/core/v4alu_pkg.sv
// ----------------------------------------------------------------------------
// v4alu_pkg
// Operation codes, sequencer states and the control word shared by the
// front end and the execution back end of the vector unit.
// ----------------------------------------------------------------------------
package v4alu_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_NEG   = 3'd2,
    OP_SCALE = 3'd3,
    OP_DOT   = 3'd4,
    OP_CROSS = 3'd5,
    OP_MAG   = 3'd6,
    OP_NORM  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    IT_IDLE,
    IT_SQRT,
    IT_DIV,
    IT_DONE
  } it_state_t;

  // classification of one request, produced by the front end
  typedef struct packed {
    op_t  op;
    logic eq;
  } ctl_t;

endpackage

>>> rtl/core/v4alu_fifo.sv
// ----------------------------------------------------------------------------
// v4alu_fifo
// Small register queue with full and empty flags, read data from the head.
// ----------------------------------------------------------------------------
module v4alu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CNW-1:0]   count;

  logic do_wr;
  logic do_rd;

  assign full  = (count == CNW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

>>> rtl/core/v4alu_front.sv
// ----------------------------------------------------------------------------
// v4alu_front
// Classify an incoming request: decode the operation and compare a with b.
// ----------------------------------------------------------------------------
module v4alu_front #(
  parameter int CW = 32
) (
  input  logic [2:0]           func,
  input  logic [3:0][CW-1:0]   a,
  input  logic [3:0][CW-1:0]   b,
  output v4alu_pkg::ctl_t      ctl
);

  always_comb begin
    ctl.op = v4alu_pkg::op_t'(func);
    ctl.eq = (a == b);
  end

endmodule

>>> rtl/core/v4alu_back.sv
// ----------------------------------------------------------------------------
// v4alu_back
// Execution back end: a product stage, a result stage with saturation, and
// a bit-serial square root and divide sequencer for magnitude and normalize.
// ----------------------------------------------------------------------------
module v4alu_back #(
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  v4alu_pkg::ctl_t       in_ctl,
  input  logic signed [CW-1:0]  in_a [4],
  input  logic signed [CW-1:0]  in_b [4],
  input  logic signed [CW-1:0]  in_s,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CW-1:0]         out_r [4],
  output logic [CW-1:0]         out_rs,
  output logic                  out_eq,
  output logic                  out_flag
);

  localparam int PW   = 2 * CW;
  localparam int NW   = CW + F;
  localparam int SW   = (2 * CW + 2 > NW + 1) ? 2 * CW + 2 : NW + 1;
  localparam int RADW = 2 * CW + 2;
  localparam int REMW = CW + 4;
  localparam int CNTW = $clog2(NW + 1);

  function automatic logic [CW:0] sat(input logic signed [SW-1:0] v);
    logic [SW-CW:0] top;
    top = v[SW-1:CW-1];
    if ((&top) || !(|top)) begin
      sat = {1'b0, v[CW-1:0]};
    end else if (v[SW-1]) begin
      sat = {2'b11, {(CW-1){1'b0}}};
    end else begin
      sat = {2'b10, {(CW-1){1'b1}}};
    end
  endfunction

  // ---- product stage ----
  logic signed [CW-1:0] ma [6];
  logic signed [CW-1:0] mb [6];

  logic                 s1_valid;
  v4alu_pkg::op_t       s1_op;
  logic                 s1_eq;
  logic signed [CW-1:0] s1_a [4];
  logic signed [CW-1:0] s1_b [4];
  logic signed [PW-1:0] s1_p [6];

  logic s1_adv;
  logic s1_load;
  logic ex_done;
  logic is_iter;

  always_comb begin
    ma[4] = in_a[0];
    mb[4] = in_b[2];
    ma[5] = in_a[1];
    mb[5] = in_b[0];
    for (int i = 0; i < 4; i++) begin
      ma[i] = in_a[i];
      mb[i] = in_a[i];
    end
    unique case (in_ctl.op)
      v4alu_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          ma[i] = in_s;
        end
      end
      v4alu_pkg::OP_DOT: begin
        for (int i = 0; i < 4; i++) begin
          mb[i] = in_b[i];
        end
      end
      v4alu_pkg::OP_CROSS: begin
        ma[0] = in_a[1];
        mb[0] = in_b[2];
        ma[1] = in_a[2];
        mb[1] = in_b[0];
        ma[2] = in_a[0];
        mb[2] = in_b[1];
        ma[3] = in_a[2];
        mb[3] = in_b[1];
      end
      default: begin
      end
    endcase
  end

  assign in_ready = !s1_valid || s1_adv;
  assign s1_load  = in_valid && in_ready;
  assign is_iter  = (s1_op == v4alu_pkg::OP_MAG) || (s1_op == v4alu_pkg::OP_NORM);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op <= in_ctl.op;
      s1_eq <= in_ctl.eq;
      for (int i = 0; i < 4; i++) begin
        s1_a[i] <= in_a[i];
        s1_b[i] <= in_b[i];
      end
      for (int i = 0; i < 6; i++) begin
        s1_p[i] <= ma[i] * mb[i];
      end
    end
  end

  // ---- square root and divide sequencer ----
  v4alu_pkg::it_state_t state;
  v4alu_pkg::it_state_t state_next;

  logic [CNTW-1:0] cnt;
  logic [RADW-1:0] rad;
  logic [REMW-1:0] rem;
  logic [CW:0]     root;
  logic [NW-1:0]   dnum [4];
  logic [CW+1:0]   drem [4];

  logic [RADW-1:0] rad_load;
  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic            sq_ge;
  logic [REMW-1:0] rem_next;
  logic [CW:0]     root_next;
  logic [CW+1:0]   dsh [4];
  logic            dge [4];
  logic [CW-1:0]   abs_a [4];

  always_comb begin
    rad_load = RADW'($unsigned(s1_p[0])) + RADW'($unsigned(s1_p[1]))
             + RADW'($unsigned(s1_p[2])) + RADW'($unsigned(s1_p[3]));
    rem_sh    = {rem[REMW-3:0], rad[RADW-1:RADW-2]};
    trial     = {1'b0, root, 2'b01};
    sq_ge     = (rem_sh >= trial);
    rem_next  = sq_ge ? rem_sh - trial : rem_sh;
    root_next = {root[CW-1:0], sq_ge};
    for (int i = 0; i < 4; i++) begin
      abs_a[i] = s1_a[i][CW-1] ? CW'(0) - CW'(s1_a[i]) : CW'(s1_a[i]);
      dsh[i]   = {drem[i][CW:0], dnum[i][NW-1]};
      dge[i]   = (dsh[i] >= {1'b0, root});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= v4alu_pkg::IT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ex_done    = !is_iter;
    unique case (state)
      v4alu_pkg::IT_IDLE: begin
        if (s1_valid && is_iter) begin
          state_next = v4alu_pkg::IT_SQRT;
        end
      end
      v4alu_pkg::IT_SQRT: begin
        if (cnt == CNTW'(CW)) begin
          if (s1_op == v4alu_pkg::OP_MAG || root_next == '0) begin
            state_next = v4alu_pkg::IT_DONE;
          end else begin
            state_next = v4alu_pkg::IT_DIV;
          end
        end
      end
      v4alu_pkg::IT_DIV: begin
        if (cnt == CNTW'(NW - 1)) begin
          state_next = v4alu_pkg::IT_DONE;
        end
      end
      v4alu_pkg::IT_DONE: begin
        ex_done = 1'b1;
        if (s1_adv) begin
          state_next = v4alu_pkg::IT_IDLE;
        end
      end
      default: begin
        state_next = v4alu_pkg::IT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      v4alu_pkg::IT_IDLE: begin
        cnt  <= '0;
        rad  <= rad_load;
        rem  <= '0;
        root <= '0;
      end
      v4alu_pkg::IT_SQRT: begin
        rad  <= rad << 2;
        rem  <= rem_next;
        root <= root_next;
        cnt  <= (cnt == CNTW'(CW)) ? '0 : cnt + 1'b1;
        for (int i = 0; i < 4; i++) begin
          dnum[i] <= {abs_a[i], {F{1'b0}}};
          drem[i] <= '0;
        end
      end
      v4alu_pkg::IT_DIV: begin
        cnt <= cnt + 1'b1;
        for (int i = 0; i < 4; i++) begin
          drem[i] <= dge[i] ? dsh[i] - {1'b0, root} : dsh[i];
          dnum[i] <= {dnum[i][NW-2:0], dge[i]};
        end
      end
      default: begin
      end
    endcase
  end

  // ---- result stage ----
  logic signed [SW-1:0] lane_v [4];
  logic signed [SW-1:0] dot_v;
  logic signed [SW-1:0] qv;
  logic [CW:0]          lane_s [4];
  logic [CW:0]          sc_s;

  always_comb begin
    dot_v = (SW'(s1_p[0]) + SW'(s1_p[1]) + SW'(s1_p[2]) + SW'(s1_p[3])) >>> F;
    qv    = '0;
    for (int i = 0; i < 4; i++) begin
      lane_v[i] = '0;
    end
    sc_s = '0;
    case (s1_op)
      v4alu_pkg::OP_ADD: begin
        for (int i = 0; i < 4; i++) begin
          lane_v[i] = SW'(s1_a[i]) + SW'(s1_b[i]);
        end
      end
      v4alu_pkg::OP_SUB: begin
        for (int i = 0; i < 4; i++) begin
          lane_v[i] = SW'(s1_a[i]) - SW'(s1_b[i]);
        end
      end
      v4alu_pkg::OP_NEG: begin
        for (int i = 0; i < 4; i++) begin
          lane_v[i] = -SW'(s1_a[i]);
        end
      end
      v4alu_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          lane_v[i] = SW'(s1_p[i]) >>> F;
        end
      end
      v4alu_pkg::OP_DOT: begin
        sc_s = sat(dot_v);
      end
      v4alu_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          lane_v[i] = (SW'(s1_p[i]) - SW'(s1_p[i+3])) >>> F;
        end
      end
      v4alu_pkg::OP_MAG: begin
        sc_s = sat($signed(SW'(root)));
      end
      default: begin
        if (root != '0) begin
          for (int i = 0; i < 4; i++) begin
            qv = $signed(SW'(dnum[i]));
            lane_v[i] = s1_a[i][CW-1] ? -qv : qv;
          end
        end
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      lane_s[i] = sat(lane_v[i]);
      out_r[i]  = lane_s[i][CW-1:0];
    end
    out_rs   = sc_s[CW-1:0];
    out_eq   = s1_eq;
    out_flag = lane_s[0][CW] | lane_s[1][CW] | lane_s[2][CW] | lane_s[3][CW] | sc_s[CW]
             | ((s1_op == v4alu_pkg::OP_NORM) && (root == '0));
  end

  assign out_valid = s1_valid && ex_done;
  assign s1_adv    = out_valid && out_ready;

endmodule

>>> rtl/core/vector4_alu.sv
// ----------------------------------------------------------------------------
// vector4_alu
// Four-component signed fixed-point vector unit with saturating results.
// ----------------------------------------------------------------------------
// Path: add, sub, negate, scale, dot and cross go through the request
//   queue, the product stage and the result queue; one request per cycle
//   while the result queue has room and no magnitude or normalize request
//   holds the back end.
// Magnitude adds a bit-serial square root; normalize runs it and then the
//   four bit-serial dividers. Both hold the back end while they run.
// Reset: rst clears both queues, the product stage and the sequencer.
// ----------------------------------------------------------------------------
module vector4_alu #(
  parameter int FRAC_BITS  = 16,
  parameter int COMP_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // request side
  input  logic                         push,
  output logic                         full,
  input  logic [2:0]                   func,
  input  logic signed [COMP_WIDTH-1:0] a_x,
  input  logic signed [COMP_WIDTH-1:0] a_y,
  input  logic signed [COMP_WIDTH-1:0] a_z,
  input  logic signed [COMP_WIDTH-1:0] a_w,
  input  logic signed [COMP_WIDTH-1:0] b_x,
  input  logic signed [COMP_WIDTH-1:0] b_y,
  input  logic signed [COMP_WIDTH-1:0] b_z,
  input  logic signed [COMP_WIDTH-1:0] b_w,
  input  logic signed [COMP_WIDTH-1:0] scale_factor,
  // result side
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COMP_WIDTH-1:0] r_x,
  output logic signed [COMP_WIDTH-1:0] r_y,
  output logic signed [COMP_WIDTH-1:0] r_z,
  output logic signed [COMP_WIDTH-1:0] r_w,
  output logic signed [COMP_WIDTH-1:0] r_scalar,
  output logic                         vectors_equal,
  output logic                         range_flag
);

  localparam int CW   = COMP_WIDTH;
  localparam int CTLW = $bits(v4alu_pkg::ctl_t);
  localparam int QW   = CTLW + 9 * CW;   // request queue entry
  localparam int OW   = 5 * CW + 2;      // result queue entry

  // classify the request on the way in
  v4alu_pkg::ctl_t ctl;

  v4alu_front #(
    .CW(CW)
  ) u_front (
    .func (func),
    .a    ({a_w, a_z, a_y, a_x}),
    .b    ({b_w, b_z, b_y, b_x}),
    .ctl  (ctl)
  );

  // request queue: lets the front keep taking requests while the back stalls
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;
  logic          q_empty;
  logic          q_pop;

  assign q_wdata = {ctl, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor};

  v4alu_fifo #(
    .WIDTH(QW),
    .DEPTH(4)
  ) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .wr_en (push),
    .wdata (q_wdata),
    .rd_en (q_pop),
    .rdata (q_rdata),
    .full  (full),
    .empty (q_empty)
  );

  // unpack the head of the queue for the back end
  v4alu_pkg::ctl_t      bk_ctl;
  logic signed [CW-1:0] bk_a [4];
  logic signed [CW-1:0] bk_b [4];
  logic signed [CW-1:0] bk_s;
  logic                 bk_ready;

  always_comb begin
    bk_ctl = v4alu_pkg::ctl_t'(q_rdata[QW-1 -: CTLW]);
    for (int i = 0; i < 4; i++) begin
      bk_a[i] = q_rdata[(9-i)*CW-1 -: CW];
      bk_b[i] = q_rdata[(5-i)*CW-1 -: CW];
    end
    bk_s = q_rdata[CW-1:0];
  end

  // advance the queue head only when the back end takes it
  assign q_pop = !q_empty && bk_ready;

  logic          ex_valid;
  logic          o_full;
  logic [CW-1:0] ex_r [4];
  logic [CW-1:0] ex_rs;
  logic          ex_eq;
  logic          ex_flag;

  v4alu_back #(
    .CW(CW),
    .F (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!q_empty),
    .in_ready  (bk_ready),
    .in_ctl    (bk_ctl),
    .in_a      (bk_a),
    .in_b      (bk_b),
    .in_s      (bk_s),
    .out_valid (ex_valid),
    .out_ready (!o_full),
    .out_r     (ex_r),
    .out_rs    (ex_rs),
    .out_eq    (ex_eq),
    .out_flag  (ex_flag)
  );

  // result queue: holds finished results until the consumer pops them
  logic [OW-1:0] o_rdata;

  v4alu_fifo #(
    .WIDTH(OW),
    .DEPTH(2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr_en (ex_valid),
    .wdata ({ex_r[0], ex_r[1], ex_r[2], ex_r[3], ex_rs, ex_eq, ex_flag}),
    .rd_en (pop),
    .rdata (o_rdata),
    .full  (o_full),
    .empty (empty)
  );

  assign r_x           = o_rdata[OW-1 -: CW];
  assign r_y           = o_rdata[OW-1-CW -: CW];
  assign r_z           = o_rdata[OW-1-2*CW -: CW];
  assign r_w           = o_rdata[OW-1-3*CW -: CW];
  assign r_scalar      = o_rdata[OW-1-4*CW -: CW];
  assign vectors_equal = o_rdata[1];
  assign range_flag    = o_rdata[0];

endmodule
